[rtl/pidt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidt_pkg
// Shared types and constants of the process id table.
// ----------------------------------------------------------------------------
package pidt_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int ID_W        = 16;
  localparam int VAL_W       = 32;
  localparam int CODE_W      = 8;

  localparam logic [ID_W-1:0]   FIRST_PID_RST = 16'h3500;
  localparam logic [CODE_W-1:0] NO_CHILD_RST  = 8'd10;

  typedef enum logic [2:0] {
    REQ_ALLOC = 3'd0,
    REQ_KILL  = 3'd1,
    REQ_LINK  = 3'd2,
    REQ_WAIT  = 3'd3,
    REQ_QUERY = 3'd4
  } req_t;

  localparam logic CFG_FIRST_PID = 1'b0;
  localparam logic CFG_NO_CHILD  = 1'b1;

  typedef struct packed {
    logic             alive;
    logic             linked;
    logic             reaped;
    logic [ID_W-1:0]  parent;
    logic [CNT_W-1:0] order;
    logic [VAL_W-1:0] exit_val;
  } rec_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_FINISH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic latch;
    logic rd_tgt;
    logic rd_scan;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic is_scan;
    logic scan_last;
  } sts_t;

endpackage

[rtl/pidt_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidt_in_if / pidt_out_if
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pidt_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [15:0] proc_id;
  logic [15:0] other_id;
  logic        any_child;
  logic signed [31:0] exit_value;
  modport source (output valid, req_type, proc_id, other_id, any_child, exit_value,
                  input ready);
  modport sink (input valid, req_type, proc_id, other_id, any_child, exit_value,
                output ready);
endinterface

interface pidt_out_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [15:0] id_out;
  logic signed [31:0] value_out;
  modport source (output valid, ok, id_out, value_out, input ready);
  modport sink (input valid, ok, id_out, value_out, output ready);
endinterface

[rtl/pidt_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidt_ctrl
// Sequencer: accept, entry lookup, table scan, finish, result hold.
// ----------------------------------------------------------------------------
module pidt_ctrl
  import pidt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        state_nxt = sts.is_scan ? ST_SCAN : ST_FINISH;
      end
      ST_SCAN: begin
        if (sts.scan_last) state_nxt = ST_SCAN_LAST;
      end
      ST_SCAN_LAST: state_nxt = ST_FINISH;
      ST_FINISH:    state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      ST_LOOKUP: cmd.rd_tgt  = 1'b1;
      ST_SCAN:   cmd.rd_scan = 1'b1;
      ST_FINISH: cmd.finish  = 1'b1;
      ST_DONE:   out_valid   = 1'b1;
      default: begin
      end
    endcase
  end

endmodule

[rtl/pidt_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidt_dp
// Entry store, counters, scan tracking and result registers.
// ----------------------------------------------------------------------------
module pidt_dp
  import pidt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_idx,
  input  logic [ID_W-1:0]    cfg_wdata,
  input  logic [2:0]         in_req_type,
  input  logic [ID_W-1:0]    in_proc_id,
  input  logic [ID_W-1:0]    in_other_id,
  input  logic               in_any_child,
  input  logic [VAL_W-1:0]   in_exit_value,
  input  cmd_t               cmd,
  output sts_t               sts,
  output logic               out_ok,
  output logic [ID_W-1:0]    out_id,
  output logic [VAL_W-1:0]   out_value
);

  rec_t mem [TABLE_DEPTH];

  logic [ID_W-1:0]   first_pid_r;
  logic [CODE_W-1:0] no_child_r;
  logic [CNT_W-1:0]  next_idx_r;
  logic [CNT_W-1:0]  link_cnt_r;

  logic [2:0]        req_r;
  logic [ID_W-1:0]   pid_r;
  logic [ID_W-1:0]   oth_r;
  logic              any_r;
  logic [VAL_W-1:0]  ev_r;

  logic [CNT_W-1:0]  scan_r;
  logic              pend_r;
  logic [IDX_W-1:0]  rd_idx_r;
  rec_t              rd_data_r;
  logic              found_r;
  logic              left_r;
  logic [IDX_W-1:0]  best_idx_r;
  rec_t              best_rec_r;

  logic              ok_r;
  logic [ID_W-1:0]   id_r;
  logic [VAL_W-1:0]  val_r;

  logic [ID_W-1:0]   p_off, c_off;
  logic              p_ok, c_ok;
  logic [IDX_W-1:0]  tgt_idx, rd_addr;
  logic              rd_en;
  logic              sc_child;
  logic              is_wait;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  rec_t              wr_rec;
  logic              ok_nxt;
  logic [ID_W-1:0]   id_nxt;
  logic [VAL_W-1:0]  val_nxt;
  logic              alloc_inc, link_inc;

  assign p_off   = pid_r - first_pid_r;
  assign c_off   = oth_r - first_pid_r;
  assign p_ok    = p_off < ID_W'(next_idx_r);
  assign c_ok    = c_off < ID_W'(next_idx_r);
  assign tgt_idx = (req_r == REQ_KILL) ? p_off[IDX_W-1:0] : c_off[IDX_W-1:0];
  assign rd_addr = cmd.rd_scan ? scan_r[IDX_W-1:0] : tgt_idx;
  assign rd_en   = cmd.rd_scan | cmd.rd_tgt;
  assign is_wait = (req_r == REQ_WAIT) || (req_r == REQ_QUERY);

  assign sts.is_scan   = is_wait & any_r & p_ok;
  assign sts.scan_last = scan_r == (next_idx_r - CNT_W'(1));

  assign sc_child = rd_data_r.linked & (rd_data_r.parent == pid_r) & ~rd_data_r.reaped;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_rec;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_pid_r <= FIRST_PID_RST;
      no_child_r  <= NO_CHILD_RST;
      next_idx_r  <= '0;
      link_cnt_r  <= '0;
      pend_r      <= 1'b0;
    end else begin
      if (cfg_we && cfg_idx == CFG_FIRST_PID) first_pid_r <= cfg_wdata;
      if (cfg_we && cfg_idx == CFG_NO_CHILD)  no_child_r  <= cfg_wdata[CODE_W-1:0];
      if (alloc_inc) next_idx_r <= next_idx_r + CNT_W'(1);
      if (link_inc)  link_cnt_r <= link_cnt_r + CNT_W'(1);
      pend_r <= cmd.rd_scan;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r   <= in_req_type;
      pid_r   <= in_proc_id;
      oth_r   <= in_other_id;
      any_r   <= in_any_child;
      ev_r    <= in_exit_value;
      scan_r  <= '0;
      found_r <= 1'b0;
      left_r  <= 1'b0;
    end
    if (cmd.rd_scan) begin
      scan_r   <= scan_r + CNT_W'(1);
      rd_idx_r <= scan_r[IDX_W-1:0];
    end
    if (pend_r && sc_child) begin
      left_r <= 1'b1;
      if (!rd_data_r.alive && (!found_r || rd_data_r.order < best_rec_r.order)) begin
        found_r    <= 1'b1;
        best_idx_r <= rd_idx_r;
        best_rec_r <= rd_data_r;
      end
    end
    if (cmd.finish) begin
      ok_r  <= ok_nxt;
      id_r  <= id_nxt;
      val_r <= val_nxt;
    end
  end

  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = tgt_idx;
    wr_rec    = rd_data_r;
    ok_nxt    = 1'b0;
    id_nxt    = '0;
    val_nxt   = '0;
    alloc_inc = 1'b0;
    link_inc  = 1'b0;
    if (cmd.finish) begin
      case (req_r)
        REQ_ALLOC: begin
          if (next_idx_r < CNT_W'(TABLE_DEPTH)) begin
            ok_nxt       = 1'b1;
            alloc_inc    = 1'b1;
            wr_en        = 1'b1;
            wr_addr      = next_idx_r[IDX_W-1:0];
            wr_rec       = '0;
            wr_rec.alive = 1'b1;
            id_nxt       = first_pid_r + ID_W'(next_idx_r);
          end
        end
        REQ_KILL: begin
          if (p_ok && rd_data_r.alive) begin
            ok_nxt          = 1'b1;
            wr_en           = 1'b1;
            wr_rec.alive    = 1'b0;
            wr_rec.exit_val = ev_r;
          end
        end
        REQ_LINK: begin
          if (p_ok && c_ok && !rd_data_r.linked) begin
            ok_nxt        = 1'b1;
            link_inc      = 1'b1;
            wr_en         = 1'b1;
            wr_rec.linked = 1'b1;
            wr_rec.parent = pid_r;
            wr_rec.order  = link_cnt_r;
          end
        end
        REQ_WAIT, REQ_QUERY: begin
          if (p_ok && !any_r) begin
            if (c_ok && sc_child && !rd_data_r.alive) begin
              ok_nxt = 1'b1;
              if (req_r == REQ_WAIT) begin
                wr_en         = 1'b1;
                wr_rec.reaped = 1'b1;
                id_nxt        = oth_r;
                val_nxt       = rd_data_r.exit_val;
              end
            end
          end else if (p_ok) begin
            if (found_r) begin
              ok_nxt = 1'b1;
              if (req_r == REQ_WAIT) begin
                wr_en         = 1'b1;
                wr_addr       = best_idx_r;
                wr_rec        = best_rec_r;
                wr_rec.reaped = 1'b1;
                id_nxt        = first_pid_r + ID_W'(best_idx_r);
                val_nxt       = best_rec_r.exit_val;
              end
            end else if (!left_r) begin
              ok_nxt = 1'b1;
              if (req_r == REQ_WAIT) val_nxt = VAL_W'(no_child_r);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_ok    = ok_r;
  assign out_id    = id_r;
  assign out_value = val_r;

endmodule

[rtl/process_id_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// process_id_table
// Process table: allocate ids, kill, link child to parent, wait/reap, query.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  in_ch     in   valid/ready        req_type proc_id other_id any_child exit_value
//  out_ch    out  valid/ready        ok id_out value_out
//  cfg_*     in   cfg_we             cfg_idx cfg_wdata (first_pid, no_child_code)
//
//  Allocate, kill, link, specific wait and query: accept, entry lookup, finish, result hold.
//  Any-child wait/query on a known parent: accept, lookup, scan of all N ids allocated
//  (one entry read per cycle from the single-port entry store), finish, result hold.
//  One item at a time; the next item is taken once the result has been taken.
//  Reset: synchronous, active low; no clearing pass, entries are written on allocate.
// ----------------------------------------------------------------------------
module process_id_table
  import pidt_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  pidt_in_if.sink         in_ch,
  pidt_out_if.source      out_ch,
  input  logic            cfg_we,
  input  logic            cfg_idx,
  input  logic [ID_W-1:0] cfg_wdata
);

  cmd_t             cmd;
  sts_t             sts;
  logic [VAL_W-1:0] value_w;

  pidt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pidt_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata),
    .in_req_type   (in_ch.req_type),
    .in_proc_id    (in_ch.proc_id),
    .in_other_id   (in_ch.other_id),
    .in_any_child  (in_ch.any_child),
    .in_exit_value (in_ch.exit_value),
    .cmd           (cmd),
    .sts           (sts),
    .out_ok        (out_ch.ok),
    .out_id        (out_ch.id_out),
    .out_value     (value_w)
  );

  assign out_ch.value_out = value_w;

endmodule

[dv/process_id_table_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// process_id_table_checker
// Watches the request and result channels and the register port, keeps its
// own copy of the process table, predicts the result of every accepted item
// and compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module process_id_table_checker
  import pidt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [2:0]        in_req_type,
  input  logic [15:0]       in_proc_id,
  input  logic [15:0]       in_other_id,
  input  logic              in_any_child,
  input  logic [31:0]       in_exit_value,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic              out_ok,
  input  logic [15:0]       out_id_out,
  input  logic [31:0]       out_value_out,
  input  logic              cfg_we,
  input  logic              cfg_idx,
  input  logic [ID_W-1:0]   cfg_wdata,
  output int                fail_count,
  output int                pending
);

  typedef struct packed {
    logic        ok;
    logic [15:0] id;
    logic [31:0] val;
  } reply_t;

  reply_t expected_replies[$];

  logic [15:0] base_pid;
  logic [7:0]  no_child_val;
  int          used_entries;
  int          link_seq;
  logic        alive_q   [TABLE_DEPTH];
  logic        linked_q  [TABLE_DEPTH];
  logic        reaped_q  [TABLE_DEPTH];
  logic [15:0] parent_q  [TABLE_DEPTH];
  int          order_q   [TABLE_DEPTH];
  logic [31:0] exit_q    [TABLE_DEPTH];

  assign pending = expected_replies.size();

  function automatic int find_entry(logic [15:0] id);
    logic [15:0] idx;
    idx = id - base_pid;
    if (int'(idx) >= used_entries) return -1;
    return int'(idx);
  endfunction

  function automatic logic child_open(int c, logic [15:0] parent);
    return linked_q[c] && parent_q[c] == parent && !reaped_q[c];
  endfunction

  task automatic predict_reply(input logic [2:0] req, input logic [15:0] pid,
                               input logic [15:0] oth, input logic any,
                               input logic [31:0] ev, output reply_t r);
    int  p;
    int  c;
    int  best;
    logic left;
    r = '0;
    case (req)
      REQ_ALLOC: begin
        if (used_entries < TABLE_DEPTH) begin
          c = used_entries;
          alive_q[c] = 1'b1;
          linked_q[c] = 1'b0;
          reaped_q[c] = 1'b0;
          parent_q[c] = '0;
          order_q[c] = 0;
          exit_q[c] = '0;
          r.id = base_pid + 16'(c);
          r.ok = 1'b1;
          used_entries++;
        end
      end
      REQ_KILL: begin
        p = find_entry(pid);
        if (p >= 0 && alive_q[p]) begin
          alive_q[p] = 1'b0;
          exit_q[p] = ev;
          r.ok = 1'b1;
        end
      end
      REQ_LINK: begin
        p = find_entry(pid);
        c = find_entry(oth);
        if (p >= 0 && c >= 0 && !linked_q[c]) begin
          linked_q[c] = 1'b1;
          parent_q[c] = pid;
          order_q[c] = link_seq;
          link_seq++;
          r.ok = 1'b1;
        end
      end
      REQ_WAIT, REQ_QUERY: begin
        p = find_entry(pid);
        if (p >= 0) begin
          if (!any) begin
            c = find_entry(oth);
            if (c >= 0 && child_open(c, pid) && !alive_q[c]) begin
              r.ok = 1'b1;
              if (req == REQ_WAIT) begin
                reaped_q[c] = 1'b1;
                r.id = oth;
                r.val = exit_q[c];
              end
            end
          end else begin
            best = -1;
            left = 1'b0;
            for (int i = 0; i < used_entries; i++) begin
              if (child_open(i, pid)) begin
                left = 1'b1;
                if (!alive_q[i] && (best < 0 || order_q[i] < order_q[best])) best = i;
              end
            end
            if (best >= 0) begin
              r.ok = 1'b1;
              if (req == REQ_WAIT) begin
                reaped_q[best] = 1'b1;
                r.id = base_pid + 16'(best);
                r.val = exit_q[best];
              end
            end else if (!left) begin
              r.ok = 1'b1;
              if (req == REQ_WAIT) r.val = 32'(no_child_val);
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    reply_t r;
    reply_t e;
    if (!rst_n) begin
      base_pid = FIRST_PID_RST;
      no_child_val = NO_CHILD_RST;
      used_entries = 0;
      link_seq = 0;
      expected_replies.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == CFG_FIRST_PID) base_pid = cfg_wdata;
        else no_child_val = cfg_wdata[7:0];
      end
      if (out_valid && out_ready) begin
        r.ok = out_ok;
        r.id = out_id_out;
        r.val = out_value_out;
        if (expected_replies.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result ok=%0b id=%h val=%h", r.ok, r.id, r.val);
        end else begin
          e = expected_replies.pop_front();
          if (e !== r) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result mismatch: expected ok=%0b id=%h val=%h, got ok=%0b id=%h val=%h",
                       e.ok, e.id, e.val, r.ok, r.id, r.val);
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_reply(in_req_type, in_proc_id, in_other_id, in_any_child, in_exit_value, r);
        expected_replies.insert(expected_replies.size(), r);
      end
    end
  end

endmodule

[dv/process_id_table_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// process_id_table_tb
// Drives directed and random requests into the process table through several
// idle/stall phases and register settings; the checker judges every result.
// ----------------------------------------------------------------------------
module process_id_table_tb;
  import pidt_pkg::*;

  localparam int LIMIT = 3000000;

  logic            clk;
  logic            rst_n;
  logic            cfg_we;
  logic            cfg_idx;
  logic [ID_W-1:0] cfg_wdata;
  int              fail_count;
  int              pending;
  int              cycles = 0;
  int              send_idle_pct;
  int              recv_stall_pct;
  int              alloc_count;
  logic [15:0]     cur_base;

  pidt_in_if  in_ch ();
  pidt_out_if out_ch ();

  process_id_table DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  process_id_table_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_req_type(in_ch.req_type),
    .in_proc_id(in_ch.proc_id), .in_other_id(in_ch.other_id),
    .in_any_child(in_ch.any_child), .in_exit_value(in_ch.exit_value),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_ok(out_ch.ok),
    .out_id_out(out_ch.id_out), .out_value_out(out_ch.value_out),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("process_id_table: mismatch");
      $finish;
    end
  end

  always @(posedge clk)
    out_ch.ready <= (int'($urandom_range(0, 99)) >= recv_stall_pct);

  task automatic send_req(input logic [2:0] req, input logic [15:0] pid,
                          input logic [15:0] oth, input logic any, input logic [31:0] ev);
    in_ch.valid <= 1'b1;
    in_ch.req_type <= req;
    in_ch.proc_id <= pid;
    in_ch.other_id <= oth;
    in_ch.any_child <= any;
    in_ch.exit_value <= ev;
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
    if (req == REQ_ALLOC) alloc_count++;
    if (int'($urandom_range(0, 99)) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic idx, input logic [ID_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_FIRST_PID) cur_base = data;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_id();
    int n;
    n = (alloc_count > TABLE_DEPTH) ? TABLE_DEPTH : alloc_count;
    if (n == 0 || $urandom_range(0, 9) == 0) return 16'($urandom);
    return cur_base + 16'($urandom_range(0, n - 1));
  endfunction

  task automatic random_req();
    int r;
    r = $urandom_range(0, 99);
    if (r < 28) send_req(REQ_ALLOC, 16'($urandom), 16'($urandom), 1'($urandom), $urandom);
    else if (r < 45) send_req(REQ_KILL, pick_id(), 16'($urandom), 1'($urandom), $urandom);
    else if (r < 65) send_req(REQ_LINK, pick_id(), pick_id(), 1'($urandom), $urandom);
    else if (r < 85) send_req(REQ_WAIT, pick_id(), pick_id(), 1'($urandom), $urandom);
    else if (r < 97) send_req(REQ_QUERY, pick_id(), pick_id(), 1'($urandom), $urandom);
    else send_req(3'($urandom_range(5, 7)), 16'($urandom), 16'($urandom),
                  1'($urandom), $urandom);
  endtask

  initial begin
    logic [15:0] p0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_FIRST_PID;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_ALLOC;
    in_ch.proc_id = '0;
    in_ch.other_id = '0;
    in_ch.any_child = 1'b0;
    in_ch.exit_value = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    alloc_count = 0;
    cur_base = FIRST_PID_RST;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: parent p0 with children p0+1, p0+2
    p0 = cur_base;
    send_req(REQ_KILL, p0, 16'h0, 1'b0, 32'h1);
    send_req(REQ_ALLOC, 16'hFFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
    send_req(REQ_ALLOC, 16'h0, 16'h0, 1'b0, 32'h0);
    send_req(REQ_ALLOC, 16'h0, 16'h0, 1'b0, 32'h0);
    send_req(REQ_WAIT, p0, 16'h0, 1'b1, 32'h0);
    send_req(REQ_LINK, p0, p0 + 16'd1, 1'b0, 32'h0);
    send_req(REQ_LINK, p0, p0 + 16'd2, 1'b0, 32'h0);
    send_req(REQ_LINK, p0 + 16'd2, p0 + 16'd1, 1'b0, 32'h0);
    send_req(REQ_LINK, p0, 16'hFFFF, 1'b0, 32'h0);
    send_req(REQ_WAIT, p0, p0 + 16'd1, 1'b0, 32'h0);
    send_req(REQ_QUERY, p0, 16'h0, 1'b1, 32'h0);
    send_req(REQ_KILL, p0 + 16'd2, 16'h0, 1'b0, 32'h8000_0000);
    send_req(REQ_KILL, p0 + 16'd1, 16'h0, 1'b0, 32'h7FFF_FFFF);
    send_req(REQ_KILL, p0 + 16'd1, 16'h0, 1'b0, 32'h5);
    send_req(REQ_QUERY, p0, p0 + 16'd1, 1'b0, 32'h0);
    send_req(REQ_WAIT, p0, p0 + 16'd1, 1'b0, 32'h0);
    send_req(REQ_WAIT, p0, p0 + 16'd1, 1'b0, 32'h0);
    send_req(REQ_QUERY, p0, p0 + 16'd1, 1'b0, 32'h0);
    send_req(REQ_WAIT, p0, 16'h0, 1'b1, 32'h0);
    send_req(REQ_QUERY, p0, 16'h0, 1'b1, 32'h0);
    send_req(REQ_WAIT, p0, 16'h0, 1'b1, 32'h0);
    send_req(3'd5, 16'hFFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
    send_req(3'd6, p0, p0, 1'b0, 32'h0);
    send_req(3'd7, p0, p0, 1'b1, 32'h1);
    settle();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      case (ph)
        1: write_reg(CFG_NO_CHILD, 16'h00FF);
        2: write_reg(CFG_FIRST_PID, 16'hFFFF);
        3: write_reg(CFG_NO_CHILD, 16'h0000);
        4: write_reg(CFG_FIRST_PID, 16'h0000);
        5: write_reg(CFG_NO_CHILD, 16'(($urandom_range(0, 255))));
        6: write_reg(CFG_FIRST_PID, 16'($urandom));
        7: write_reg(CFG_FIRST_PID, FIRST_PID_RST);
        default: ;
      endcase
      repeat (110) random_req();
      settle();
    end

    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("process_id_table: match");
    end else begin
      $display("process_id_table: mismatch");
    end
    $finish;
  end

endmodule

[process_id_table.f]
rtl/pidt_pkg.sv
rtl/pidt_if.sv
rtl/pidt_ctrl.sv
rtl/pidt_dp.sv
rtl/process_id_table.sv
dv/process_id_table_checker.sv
dv/process_id_table_tb.sv
